@@ hw/rtl/lgs_pkg.sv @@
// ---------------------------------------------------------------------------
// lgs_pkg
// Shared codes, widths and the controller-to-datapath command bundle.
// ---------------------------------------------------------------------------
package lgs_pkg;

    localparam int CFG_W   = 6;
    localparam int COUNT_W = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = 11'h7FF;
    localparam logic [CFG_W-1:0]   CFG_DIM_RESET = 6'd32;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_STEP  = 2'd2;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [3:0] NBR_BIRTH = 4'd3;
    localparam logic [3:0] NBR_KEEP  = 4'd2;

    typedef struct packed {
        logic latch;
        logic cell_rd;
        logic cell_wr;
        logic cell_out;
        logic step_clr;
        logic step_rd;
        logic load_mid;
        logic load_dn;
        logic calc;
        logic cnt;
        logic shift;
        logic shift_fill;
        logic finish;
    } t_dp_cmd;

endpackage

@@ hw/rtl/lgs_dpath.sv @@
// ---------------------------------------------------------------------------
// lgs_dpath
// Two row-wide grid banks, three-row window, row rule evaluation and the
// serial change counter.
// ---------------------------------------------------------------------------
module lgs_dpath #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lgs_pkg::t_dp_cmd                  i_cmd,
    input  logic [4:0]                        i_row,
    input  logic [4:0]                        i_col,
    input  logic                              i_alive_in,
    input  logic [lgs_pkg::CFG_W-1:0]         i_rows_cfg,
    input  logic [lgs_pkg::CFG_W-1:0]         i_cols_cfg,
    input  logic [$clog2(MAX_ROWS)-1:0]       i_step_row,
    input  logic [$clog2(MAX_ROWS)-1:0]       i_rd_row,
    output logic                              o_alive_out,
    output logic [lgs_pkg::COUNT_W-1:0]       o_change_count
);

    localparam int RIW = $clog2(MAX_ROWS);
    localparam int CIW = $clog2(MAX_COLS);
    localparam int RCW = (RIW + 1 > lgs_pkg::CFG_W) ? RIW + 1 : lgs_pkg::CFG_W;
    localparam int CCW = (CIW + 1 > lgs_pkg::CFG_W) ? CIW + 1 : lgs_pkg::CFG_W;

    logic [MAX_COLS-1:0]         r_mem [2][MAX_ROWS];
    logic [1:0][MAX_ROWS-1:0]    r_valid;
    logic                        r_active;
    logic [lgs_pkg::COUNT_W-1:0] r_changes;
    logic                        r_alive;

    logic [RIW-1:0]      r_cell_row;
    logic [CIW-1:0]      r_cell_col;
    logic                r_cell_val;
    logic                r_cell_ok;

    logic [MAX_COLS-1:0] r_rd_raw;
    logic                r_rd_vld;
    logic [MAX_COLS-1:0] r_up;
    logic [MAX_COLS-1:0] r_mid;
    logic [MAX_COLS-1:0] r_dn;
    logic [MAX_COLS-1:0] r_chg;

    logic                rd_en;
    logic [RIW-1:0]      rd_row;
    logic [MAX_COLS-1:0] rd_data;
    logic [MAX_COLS-1:0] cell_row_mod;
    logic                wr_en;
    logic                wr_bank;
    logic [RIW-1:0]      wr_row;
    logic [MAX_COLS-1:0] wr_data;

    logic [MAX_COLS-1:0] colmask;
    logic                up_ok;
    logic                mid_ok;
    logic                dn_ok;
    logic [MAX_COLS-1:0] up_m;
    logic [MAX_COLS-1:0] mid_m;
    logic [MAX_COLS-1:0] dn_m;
    logic [MAX_COLS+1:0] up_p;
    logic [MAX_COLS+1:0] mid_p;
    logic [MAX_COLS+1:0] dn_p;
    logic [3:0]          nbr [MAX_COLS];
    logic [MAX_COLS-1:0] nxt;
    logic [MAX_COLS-1:0] new_row;
    logic [MAX_COLS-1:0] chg;

    assign rd_en   = i_cmd.cell_rd | i_cmd.step_rd;
    assign rd_row  = i_cmd.cell_rd ? r_cell_row : i_rd_row;
    assign rd_data = r_rd_vld ? r_rd_raw : '0;

    always_comb begin
        cell_row_mod = rd_data;
        cell_row_mod[r_cell_col] = r_cell_val;
    end

    assign wr_en   = (i_cmd.cell_wr & r_cell_ok) | i_cmd.calc;
    assign wr_bank = i_cmd.calc ? ~r_active : r_active;
    assign wr_row  = i_cmd.calc ? i_step_row : r_cell_row;
    assign wr_data = i_cmd.calc ? new_row : cell_row_mod;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_raw <= r_mem[r_active][rd_row];
            r_rd_vld <= r_valid[r_active][rd_row];
        end
        if (wr_en) begin
            r_mem[wr_bank][wr_row] <= wr_data;
        end
    end

    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            colmask[c] = CCW'(c) < CCW'(i_cols_cfg);
        end
    end

    assign up_ok  = RCW'(i_step_row) <= RCW'(i_rows_cfg);
    assign mid_ok = RCW'(i_step_row) <  RCW'(i_rows_cfg);
    assign dn_ok  = (RCW'(i_step_row) + RCW'(1)) < RCW'(i_rows_cfg);

    assign up_m  = up_ok  ? (r_up  & colmask) : '0;
    assign mid_m = mid_ok ? (r_mid & colmask) : '0;
    assign dn_m  = dn_ok  ? (r_dn  & colmask) : '0;

    assign up_p  = {1'b0, up_m,  1'b0};
    assign mid_p = {1'b0, mid_m, 1'b0};
    assign dn_p  = {1'b0, dn_m,  1'b0};

    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            nbr[c] = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
                   + 4'(mid_p[c]) + 4'(mid_p[c+2])
                   + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
            nxt[c] = (nbr[c] == lgs_pkg::NBR_BIRTH)
                   | (mid_m[c] & (nbr[c] == lgs_pkg::NBR_KEEP));
            new_row[c] = (mid_ok & colmask[c]) ? nxt[c] : r_mid[c];
            chg[c]     = mid_ok & colmask[c] & (nxt[c] != mid_m[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cell_row <= RIW'(i_row);
            r_cell_col <= CIW'(i_col);
            r_cell_val <= i_alive_in;
            r_cell_ok  <= (32'(i_row) < MAX_ROWS) && (32'(i_col) < MAX_COLS);
        end
        if (i_cmd.step_clr) begin
            r_up  <= '0;
            r_mid <= '0;
            r_dn  <= '0;
        end else if (i_cmd.shift) begin
            r_up  <= r_mid;
            r_mid <= r_dn;
            r_dn  <= i_cmd.shift_fill ? rd_data : '0;
        end else begin
            if (i_cmd.load_mid) begin
                r_mid <= rd_data;
            end
            if (i_cmd.load_dn) begin
                r_dn <= rd_data;
            end
        end
        if (i_cmd.calc) begin
            r_chg <= chg;
        end else if (i_cmd.cnt) begin
            r_chg <= r_chg >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_active  <= 1'b0;
            r_changes <= '0;
            r_alive   <= 1'b0;
        end else begin
            if (i_cmd.cell_wr && r_cell_ok) begin
                r_valid[r_active][r_cell_row] <= 1'b1;
            end
            if (i_cmd.calc) begin
                r_valid[~r_active][i_step_row] <= 1'b1;
            end
            if (i_cmd.step_clr) begin
                r_changes <= '0;
            end else if (i_cmd.cnt && r_chg[0] && (r_changes != lgs_pkg::COUNT_MAX)) begin
                r_changes <= r_changes + 1'b1;
            end
            if (i_cmd.finish) begin
                r_active <= ~r_active;
            end
            if (i_cmd.latch) begin
                r_alive <= 1'b0;
            end else if (i_cmd.cell_out) begin
                r_alive <= r_cell_ok & rd_data[r_cell_col];
            end
        end
    end

    assign o_alive_out    = r_alive;
    assign o_change_count = r_changes;

endmodule

@@ hw/rtl/lgs_ctrl.sv @@
// ---------------------------------------------------------------------------
// lgs_ctrl
// Transaction sequencer: cell access and the row-by-row generation sweep.
// ---------------------------------------------------------------------------
module lgs_ctrl #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [1:0]                  i_mode,
    output lgs_pkg::t_dp_cmd            o_cmd,
    output logic [$clog2(MAX_ROWS)-1:0] o_step_row,
    output logic [$clog2(MAX_ROWS)-1:0] o_rd_row,
    output logic                        o_busy,
    output logic                        o_done
);

    localparam int RIW = $clog2(MAX_ROWS);
    localparam int CIW = $clog2(MAX_COLS);

    localparam logic [RIW-1:0] LAST_ROW = RIW'(MAX_ROWS - 1);
    localparam logic [CIW-1:0] LAST_COL = CIW'(MAX_COLS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CRD   = 3'd1;
    localparam logic [2:0] S_CFIN  = 3'd2;
    localparam logic [2:0] S_SINIT = 3'd3;
    localparam logic [2:0] S_SL0   = 3'd4;
    localparam logic [2:0] S_SL1   = 3'd5;
    localparam logic [2:0] S_SCALC = 3'd6;
    localparam logic [2:0] S_SCNT  = 3'd7;

    logic [2:0]     r_state, n_state;
    logic [1:0]     r_mode,  n_mode;
    logic [RIW-1:0] r_row,   n_row;
    logic [CIW-1:0] r_col,   n_col;
    logic           r_done,  n_done;

    logic [RIW:0]   row2;
    logic           row2_ok;

    assign row2    = {1'b0, r_row} + (RIW+1)'(2);
    assign row2_ok = row2 < (RIW+1)'(MAX_ROWS);

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_row    = r_row;
        n_col    = r_col;
        n_done   = 1'b0;
        o_cmd    = '0;
        o_rd_row = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_mode      = i_mode;
                    case (i_mode)
                        lgs_pkg::MODE_WRITE: n_state = S_CRD;
                        lgs_pkg::MODE_READ:  n_state = S_CRD;
                        lgs_pkg::MODE_STEP:  n_state = S_SINIT;
                        default:             n_done  = 1'b1;
                    endcase
                end
            end
            S_CRD: begin
                o_cmd.cell_rd = 1'b1;
                n_state       = S_CFIN;
            end
            S_CFIN: begin
                o_cmd.cell_wr  = (r_mode == lgs_pkg::MODE_WRITE);
                o_cmd.cell_out = (r_mode == lgs_pkg::MODE_READ);
                n_done         = 1'b1;
                n_state        = S_IDLE;
            end
            S_SINIT: begin
                o_cmd.step_clr = 1'b1;
                o_cmd.step_rd  = 1'b1;
                n_row          = '0;
                n_state        = S_SL0;
            end
            S_SL0: begin
                o_cmd.load_mid = 1'b1;
                o_cmd.step_rd  = 1'b1;
                o_rd_row       = RIW'(1);
                n_state        = S_SL1;
            end
            S_SL1: begin
                o_cmd.load_dn = 1'b1;
                n_state       = S_SCALC;
            end
            S_SCALC: begin
                o_cmd.calc    = 1'b1;
                o_cmd.step_rd = row2_ok;
                o_rd_row      = RIW'(row2);
                n_col         = '0;
                n_state       = S_SCNT;
            end
            S_SCNT: begin
                o_cmd.cnt = 1'b1;
                if (r_col == LAST_COL) begin
                    if (r_row == LAST_ROW) begin
                        o_cmd.finish = 1'b1;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.shift      = 1'b1;
                        o_cmd.shift_fill = row2_ok;
                        n_row            = r_row + 1'b1;
                        n_state          = S_SCALC;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_mode  <= lgs_pkg::MODE_WRITE;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_mode  <= n_mode;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    assign o_step_row = r_row;
    assign o_busy     = (r_state != S_IDLE);
    assign o_done     = r_done;

endmodule

@@ hw/rtl/life_grid_generation_step.sv @@
// ---------------------------------------------------------------------------
// life_grid_generation_step
// B3/S23 grid, no wrap, two row-wide banks swapped after each generation.
// Cell write/read: o_done follows the S_CRD and S_CFIN states; unused mode: o_done
// is raised from S_IDLE. Generation: S_SINIT, S_SL0 and S_SL1 load the window, then
// each row takes S_SCALC and S_SCNT, whose change counter takes one column per cycle.
// One transaction at a time; o_done is a single-cycle strobe, no back-pressure.
// Synchronous active-low reset: grid reads as dead, regions 32x32, count zero.
// ---------------------------------------------------------------------------
module life_grid_generation_step #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    output logic                         o_done,
    input  logic [1:0]                   i_mode,
    input  logic [4:0]                   i_row,
    input  logic [4:0]                   i_col,
    input  logic                         i_alive_in,
    output logic                         o_alive_out,
    output logic [lgs_pkg::COUNT_W-1:0]  o_change_count,
    input  logic                         i_cfg_wr_en,
    input  logic                         i_cfg_addr,
    input  logic [lgs_pkg::CFG_W-1:0]    i_cfg_wdata
);

    localparam int RIW = $clog2(MAX_ROWS);

    logic [lgs_pkg::CFG_W-1:0] r_rows_cfg;
    logic [lgs_pkg::CFG_W-1:0] r_cols_cfg;

    lgs_pkg::t_dp_cmd cmd;
    logic [RIW-1:0]   step_row;
    logic [RIW-1:0]   rd_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= lgs_pkg::CFG_DIM_RESET;
            r_cols_cfg <= lgs_pkg::CFG_DIM_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                lgs_pkg::CFG_ROWS: r_rows_cfg <= i_cfg_wdata;
                lgs_pkg::CFG_COLS: r_cols_cfg <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    lgs_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_mode     (i_mode),
        .o_cmd      (cmd),
        .o_step_row (step_row),
        .o_rd_row   (rd_row),
        .o_busy     (o_busy),
        .o_done     (o_done)
    );

    lgs_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_alive_in     (i_alive_in),
        .i_rows_cfg     (r_rows_cfg),
        .i_cols_cfg     (r_cols_cfg),
        .i_step_row     (step_row),
        .i_rd_row       (rd_row),
        .o_alive_out    (o_alive_out),
        .o_change_count (o_change_count)
    );

    a_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("done while busy");

    a_cell_timing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy &&
         (i_mode == lgs_pkg::MODE_WRITE || i_mode == lgs_pkg::MODE_READ))
        |=> o_busy ##1 !o_done ##1 o_done)
        else $error("cell transaction latency wrong");

    a_count_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && $past(!o_busy)) |-> $stable(o_change_count))
        else $error("change count moved while idle");

endmodule
